@@ hdl/rtpfua_pkg.sv @@
// shared constants for the h264 rtp fu-a packetizer
// no dependencies
package rtpfua_pkg;
	localparam int NAL_LENGTH_BITS = 24;
	localparam logic [2:0] REG_MTU = 3'd0;
	localparam logic [2:0] REG_PT = 3'd1;
	localparam logic [2:0] REG_CHAN = 3'd2;
	localparam logic [2:0] REG_SSRC = 3'd3;
	localparam logic [2:0] REG_TICKS = 3'd4;
	localparam logic [2:0] REG_CYCLE = 3'd5;
	localparam logic [7:0] DOLLAR = 8'h24;
	localparam logic [7:0] RTP_V2 = 8'h80;
	localparam logic [7:0] FU_A_TYPE = 8'd28;
	localparam logic [4:0] IDR_TYPE = 5'd5;

	// controller to datapath
	typedef struct packed {
		logic start_div;  // begin stamp modulo
		logic start_mul;  // begin ticks multiply
		logic latch_nal;  // take first-byte fields
		logic open_pkt;   // compute packet size, select header
		logic [4:0] hdr_idx; // header byte index
		logic emit_hdr;
		logic emit_pay;
		logic bump_seq;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic mul_done;
		logic frag;       // unit takes fu-a mode
		logic need_pkt;   // next payload byte opens a fragment
		logic pay_last;   // payload byte closes packet
		logic unit_open;  // unit in progress
		logic zero_len;
	} sts_t;
endpackage

@@ hdl/rtpfua_datapath.sv @@
// datapath: config registers, stamp modulo and multiply, counters, byte mux
// depends on rtpfua_pkg
module rtpfua_datapath import rtpfua_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [31:0] cfg_data,
	input  logic [7:0] in_byte,
	input  logic [NAL_LENGTH_BITS-1:0] in_len,
	input  logic in_first,
	input  logic [31:0] in_stamp,
	input  logic in_take,
	input  cmd_t cmd,
	output sts_t sts,
	output logic [7:0] byte_o,
	output logic last_o,
	output logic key_o
);
	logic [15:0] mtu_q;
	logic [6:0] pt_q;
	logic [7:0] chan_q, hdr_q, pay_q;
	logic [31:0] ssrc_q, cycle_q, ts_q, stamp_q;
	logic [22:0] ticks_q;
	logic [15:0] seq_q, frem_q, plen_q;
	logic [NAL_LENGTH_BITS-1:0] off_q, tot_q;
	logic frag_q, pend_q, mark_q, endf_q;
	// modulo: restoring, one bit a cycle
	logic [32:0] rem_q;
	logic [31:0] quo_q;
	logic [5:0] dcnt_q;
	logic div_busy_q;
	// multiply: 8 bits of stamp a cycle
	logic [2:0] mcnt_q;
	logic mul_busy_q;
	logic [31:0] mod_q, acc_q;

	logic [15:0] chunk;
	logic [NAL_LENGTH_BITS-1:0] left;
	logic [32:0] trial;
	logic [31:0] pp;
	logic lend;

	assign chunk = (mtu_q < 16'd3) ? 16'd1 : mtu_q - 16'd2;
	assign left = tot_q - off_q;
	assign lend = left <= {{(NAL_LENGTH_BITS-16){1'b0}}, chunk};
	assign trial = {rem_q[31:0], quo_q[31]} - {1'b0, cycle_q};
	assign pp = ticks_q * mod_q[31:24];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mtu_q <= 16'd1400; pt_q <= 7'd96; chan_q <= '0; ssrc_q <= '0;
			ticks_q <= 23'd90; cycle_q <= 32'd46800000;
			seq_q <= '0; ts_q <= '0; off_q <= '0; tot_q <= '0; frem_q <= '0;
			frag_q <= 1'b0; pend_q <= 1'b0; hdr_q <= '0;
			div_busy_q <= 1'b0; mul_busy_q <= 1'b0;
			pay_q <= '0; stamp_q <= '0; rem_q <= '0; quo_q <= '0; dcnt_q <= '0;
			mcnt_q <= '0; mod_q <= '0; acc_q <= '0; plen_q <= '0;
			mark_q <= 1'b0; endf_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_MTU:   mtu_q <= cfg_data[15:0];
					REG_PT:    pt_q <= cfg_data[6:0];
					REG_CHAN:  chan_q <= cfg_data[7:0];
					REG_SSRC:  ssrc_q <= cfg_data;
					REG_TICKS: ticks_q <= cfg_data[22:0];
					REG_CYCLE: cycle_q <= cfg_data;
					default: ;
				endcase
			end
			if (in_take) begin
				pay_q <= in_byte;
				if (in_first) begin
					stamp_q <= in_stamp;
					if (in_len == '0) begin
						tot_q <= '0; off_q <= '0; frem_q <= '0;
					end
				end
			end
			if (cmd.start_div) begin
				div_busy_q <= (cycle_q != '0);
				rem_q <= '0; quo_q <= stamp_q; dcnt_q <= '0;
				mod_q <= stamp_q;
			end else if (div_busy_q) begin
				if (!trial[32]) rem_q <= trial;
				else rem_q <= {rem_q[31:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
				dcnt_q <= dcnt_q + 6'd1;
				if (dcnt_q == 6'd31) begin
					div_busy_q <= 1'b0;
					mod_q <= trial[32] ? {rem_q[30:0], quo_q[31]} : trial[31:0];
				end
			end
			if (cmd.start_mul) begin
				mul_busy_q <= 1'b1; mcnt_q <= '0; acc_q <= '0;
			end else if (mul_busy_q) begin
				acc_q <= {acc_q[23:0], 8'd0} + pp;
				mod_q <= {mod_q[23:0], 8'd0};
				mcnt_q <= mcnt_q + 3'd1;
				if (mcnt_q == 3'd3) begin
					mul_busy_q <= 1'b0;
					ts_q <= {acc_q[23:0], 8'd0} + pp;
				end
			end
			if (cmd.latch_nal) begin
				tot_q <= in_len;
				// single units count the first byte when it is sent
				off_q <= (in_len > {{(NAL_LENGTH_BITS-16){1'b0}}, chunk}) ?
					{{(NAL_LENGTH_BITS-1){1'b0}}, 1'b1} : '0;
				hdr_q <= pay_q; frem_q <= '0;
				frag_q <= in_len > {{(NAL_LENGTH_BITS-16){1'b0}}, chunk};
				pend_q <= in_len > {{(NAL_LENGTH_BITS-16){1'b0}}, chunk};
			end
			if (cmd.open_pkt) begin
				if (!frag_q) begin
					plen_q <= tot_q[15:0] + 16'd12; mark_q <= 1'b1;
				end else begin
					endf_q <= lend; mark_q <= lend;
					plen_q <= (lend ? left[15:0] : chunk) + 16'd14;
					frem_q <= lend ? left[15:0] : chunk;
				end
			end
			if (cmd.bump_seq) seq_q <= seq_q + 16'd1;
			if (cmd.emit_hdr && cmd.hdr_idx == 5'd17) pend_q <= 1'b0;
			if (cmd.emit_pay) begin
				off_q <= off_q + 1'b1;
				if (frag_q) frem_q <= frem_q - 16'd1;
			end
		end
	end

	always_comb begin
		byte_o = 8'd0; last_o = 1'b0; key_o = 1'b0;
		if (cmd.emit_hdr) begin
			unique case (cmd.hdr_idx)
				5'd0: byte_o = DOLLAR;
				5'd1: byte_o = chan_q;
				5'd2: byte_o = plen_q[15:8];
				5'd3: byte_o = plen_q[7:0];
				5'd4: byte_o = RTP_V2;
				5'd5: byte_o = {mark_q, pt_q};
				5'd6: byte_o = seq_q[15:8];
				5'd7: byte_o = seq_q[7:0];
				5'd8: byte_o = ts_q[31:24];
				5'd9: byte_o = ts_q[23:16];
				5'd10: byte_o = ts_q[15:8];
				5'd11: byte_o = ts_q[7:0];
				5'd12: byte_o = ssrc_q[31:24];
				5'd13: byte_o = ssrc_q[23:16];
				5'd14: byte_o = ssrc_q[15:8];
				5'd15: byte_o = ssrc_q[7:0];
				5'd16: byte_o = (hdr_q & 8'h60) + FU_A_TYPE;
				5'd17: byte_o = {pend_q, endf_q, 1'b0, hdr_q[4:0]};
				default: byte_o = 8'd0;
			endcase
		end else if (cmd.emit_pay) begin
			byte_o = pay_q;
			last_o = sts.pay_last;
			key_o = sts.pay_last && !frag_q && hdr_q[4:0] == IDR_TYPE;
		end
	end

	assign sts.div_done = !div_busy_q;
	assign sts.mul_done = !mul_busy_q;
	assign sts.frag = frag_q;
	assign sts.need_pkt = frem_q == '0;
	assign sts.pay_last = frag_q ? (frem_q == 16'd1)
		: (off_q + 1'b1 == tot_q);
	assign sts.unit_open = off_q < tot_q;
	assign sts.zero_len = in_len == '0;
endmodule

@@ hdl/rtpfua_ctrl.sv @@
// controller: sequences timestamp math, packet headers and payload bytes
// depends on rtpfua_pkg
module rtpfua_ctrl import rtpfua_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_first,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	input  sts_t sts,
	output cmd_t cmd
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DIV = 3'd1;
	localparam logic [2:0] S_MUL = 3'd2;
	localparam logic [2:0] S_OPEN = 3'd3;
	localparam logic [2:0] S_HDR = 3'd4;
	localparam logic [2:0] S_PAY = 3'd5;
	localparam logic [2:0] S_DECIDE = 3'd6;

	logic [2:0] state_q;
	logic [4:0] idx_q;
	logic take;

	assign in_stall = state_q != S_IDLE;
	assign take = in_valid && !in_stall;

	always_comb begin
		cmd = '0;
		cmd.hdr_idx = idx_q;
		out_valid = 1'b0;
		unique case (state_q)
			S_DECIDE: begin
				cmd.start_div = 1'b1;
				cmd.latch_nal = 1'b1;
			end
			S_DIV: cmd.start_mul = sts.div_done;
			S_MUL: ;
			S_OPEN: cmd.open_pkt = 1'b1;
			S_HDR: begin
				out_valid = 1'b1;
				cmd.emit_hdr = !out_stall;
				cmd.bump_seq = !out_stall && idx_q == 5'd15;
			end
			S_PAY: begin
				out_valid = 1'b1;
				cmd.emit_pay = !out_stall;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; idx_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (take) begin
					if (in_first) begin
						if (!sts.zero_len) state_q <= S_DECIDE;
					end else if (sts.unit_open) begin
						if (sts.frag && sts.need_pkt) state_q <= S_OPEN;
						else state_q <= S_PAY;
					end
				end
				S_DECIDE: state_q <= S_DIV;
				S_DIV: if (sts.div_done) state_q <= S_MUL;
				S_MUL: if (sts.mul_done) begin
					// single-packet units open immediately; fu-a waits for next byte
					state_q <= sts.frag ? S_IDLE : S_OPEN;
				end
				S_OPEN: begin
					idx_q <= '0; state_q <= S_HDR;
				end
				S_HDR: if (!out_stall) begin
					idx_q <= idx_q + 5'd1;
					if ((sts.frag && idx_q == 5'd17) || (!sts.frag && idx_q == 5'd15))
						state_q <= S_PAY;
				end
				S_PAY: if (!out_stall) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input taken while emitting");
	a_hdr_pay: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_HDR && !out_stall && idx_q == 5'd17) |=> state_q == S_PAY)
		else $error("fu header not followed by payload");
	a_idx: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_HDR |-> idx_q <= 5'd17) else $error("header index overrun");
endmodule

@@ hdl/h264_rtp_fua_packetizer_unit.sv @@
// sequence: a unit's first byte starts the stamp modulo, then the multiply; a single-packet unit
// then emits its header and first byte (the modulo is skipped with the cycle register 0)
// input: no new nal byte is taken until the last one is sent; a byte that opens a fragment
// first emits its fu-a header, and a fu-a unit's first byte emits nothing
// reset: asynchronous active-low arst_n restores register defaults and clears state
// top level: joins rtpfua_ctrl and rtpfua_datapath
// depends on rtpfua_pkg
module h264_rtp_fua_packetizer_unit import rtpfua_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [31:0] cfg_data,
	input  logic in_valid,
	output logic in_stall,
	input  logic [7:0] nal_byte,
	input  logic [NAL_LENGTH_BITS-1:0] nal_length,
	input  logic first_of_nal,
	input  logic [31:0] stamp_ms,
	output logic out_valid,
	input  logic out_stall,
	output logic [7:0] out_byte,
	output logic last_of_packet,
	output logic key_packet
);
	cmd_t cmd;
	sts_t sts;
	logic take;
	logic [NAL_LENGTH_BITS-1:0] len_q;

	assign take = in_valid && !in_stall;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) len_q <= '0;
		else if (take) len_q <= nal_length;
	end

	rtpfua_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_first(first_of_nal),
		.in_stall(in_stall), .out_valid(out_valid), .out_stall(out_stall),
		.sts(sts), .cmd(cmd)
	);

	rtpfua_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_byte(nal_byte), .in_len(take ? nal_length : len_q),
		.in_first(first_of_nal), .in_stamp(stamp_ms), .in_take(take), .cmd(cmd),
		.sts(sts), .byte_o(out_byte), .last_o(last_of_packet), .key_o(key_packet)
	);
endmodule

@@ dv/h264_rtp_fua_packetizer_unit_tb.sv @@
// testbench for h264_rtp_fua_packetizer_unit: nal bytes in, framed rtp stream out
// a scoreboard class predicts every stream byte and checks each out transaction
// depends on rtpfua_pkg and the packetizer rtl
`timescale 1ns / 1ps

import rtpfua_pkg::*;

class rtp_stream_sb;
	typedef struct packed {
		logic [7:0] b;
		logic last;
		logic key;
	} sbyte_t;

	logic [15:0] mtu;
	logic [6:0] pt;
	logic [7:0] chan;
	logic [31:0] ssrc;
	logic [22:0] ticks;
	logic [31:0] cyc;
	logic [15:0] seq;
	logic [31:0] ts;
	logic [23:0] offs;
	logic [23:0] total;
	logic [15:0] frag_left;
	logic frag_mode;
	logic first_frag;
	logic [7:0] hdr_byte;
	sbyte_t pending_bytes[$];
	int errors;

	function new();
		mtu = 16'd1400;
		pt = 7'd96;
		chan = 8'd0;
		ssrc = 32'd0;
		ticks = 23'd90;
		cyc = 32'd46800000;
		seq = 16'd0;
		ts = 32'd0;
		offs = 24'd0;
		total = 24'd0;
		frag_left = 16'd0;
		frag_mode = 1'b0;
		first_frag = 1'b0;
		hdr_byte = 8'd0;
		errors = 0;
	endfunction

	function void set_reg(logic [2:0] idx, logic [31:0] val);
		case (idx)
			REG_MTU: mtu = val[15:0];
			REG_PT: pt = val[6:0];
			REG_CHAN: chan = val[7:0];
			REG_SSRC: ssrc = val;
			REG_TICKS: ticks = val[22:0];
			REG_CYCLE: cyc = val;
			default: ;
		endcase
	endfunction

	function logic [31:0] chunk();
		logic [31:0] m;
		m = (mtu < 16'd3) ? 32'd3 : {16'd0, mtu};
		return m - 32'd2;
	endfunction

	function void push(logic [7:0] b, logic last, logic key);
		sbyte_t e;
		e.b = b;
		e.last = last;
		e.key = key;
		pending_bytes.push_back(e);
	endfunction

	function void push_header(logic [31:0] plen, logic mark);
		logic [15:0] l16;
		l16 = plen[15:0] + 16'd12;
		push(DOLLAR, 0, 0);
		push(chan, 0, 0);
		push(l16[15:8], 0, 0);
		push(l16[7:0], 0, 0);
		push(RTP_V2, 0, 0);
		push({mark, pt}, 0, 0);
		push(seq[15:8], 0, 0);
		push(seq[7:0], 0, 0);
		push(ts[31:24], 0, 0);
		push(ts[23:16], 0, 0);
		push(ts[15:8], 0, 0);
		push(ts[7:0], 0, 0);
		push(ssrc[31:24], 0, 0);
		push(ssrc[23:16], 0, 0);
		push(ssrc[15:8], 0, 0);
		push(ssrc[7:0], 0, 0);
		seq = seq + 16'd1;
	endfunction

	function void note_input(logic [7:0] b, logic [23:0] len, logic first, logic [31:0] stamp);
		logic [31:0] s;
		logic [63:0] prod;
		logic [31:0] left;
		logic [31:0] sz;
		logic fin;
		if (first) begin
			if (len == 0) begin
				total = 0;
				offs = 0;
				frag_left = 0;
				return;
			end
			s = (cyc != 0) ? stamp % cyc : stamp;
			prod = {41'd0, ticks} * {32'd0, s};
			ts = prod[31:0];
			total = len;
			offs = 24'd1;
			hdr_byte = b;
			frag_left = 0;
			if ({8'd0, len} > chunk()) begin
				frag_mode = 1'b1;
				first_frag = 1'b1;
				return;
			end
			frag_mode = 1'b0;
			first_frag = 1'b0;
			push_header({8'd0, len}, 1'b1);
			if (len == 24'd1)
				push(b, 1'b1, b[4:0] == IDR_TYPE);
			else
				push(b, 0, 0);
			return;
		end
		if (offs >= total)
			return;
		if (!frag_mode) begin
			offs = offs + 24'd1;
			if (offs == total)
				push(b, 1'b1, hdr_byte[4:0] == IDR_TYPE);
			else
				push(b, 0, 0);
			return;
		end
		if (frag_left == 0) begin
			left = {8'd0, total - offs};
			fin = left <= chunk();
			sz = fin ? left : chunk();
			push_header(sz + 32'd2, fin);
			push({1'b0, hdr_byte[6:5], 5'd0} + FU_A_TYPE, 0, 0);
			push({first_frag, fin, 1'b0, hdr_byte[4:0]}, 0, 0);
			first_frag = 1'b0;
			frag_left = sz[15:0];
		end
		frag_left = frag_left - 16'd1;
		offs = offs + 24'd1;
		push(b, frag_left == 0, 1'b0);
	endfunction

	function void check_byte(logic [7:0] b, logic last, logic key);
		sbyte_t e;
		if (pending_bytes.size() == 0) begin
			$display("%0t: unexpected byte %h last %b key %b", $realtime, b, last, key);
			errors++;
			return;
		end
		e = pending_bytes.pop_front();
		if (e.b !== b) begin
			$display("%0t: out_byte expected %h actual %h", $realtime, e.b, b);
			errors++;
		end
		if (e.last !== last) begin
			$display("%0t: last_of_packet expected %b actual %b", $realtime, e.last, last);
			errors++;
		end
		if (e.key !== key) begin
			$display("%0t: key_packet expected %b actual %b", $realtime, e.key, key);
			errors++;
		end
	endfunction
endclass

module h264_rtp_fua_packetizer_unit_tb;
	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [31:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic [7:0] nal_byte;
	logic [NAL_LENGTH_BITS-1:0] nal_length;
	logic first_of_nal;
	logic [31:0] stamp_ms;
	logic out_valid;
	logic out_stall;
	logic [7:0] out_byte;
	logic last_of_packet;
	logic key_packet;

	rtp_stream_sb sb;
	int idle_cycles;
	int burst_left;

	h264_rtp_fua_packetizer_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.nal_byte(nal_byte),
		.nal_length(nal_length),
		.first_of_nal(first_of_nal),
		.stamp_ms(stamp_ms),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte(out_byte),
		.last_of_packet(last_of_packet),
		.key_packet(key_packet)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// output checks and watchdog
	always @(posedge clk) begin
		if (!arst_n)
			idle_cycles = 0;
		else begin
			if (out_valid && !out_stall)
				sb.check_byte(out_byte, last_of_packet, key_packet);
			if ((out_valid && !out_stall) || (in_valid && !in_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles > 20000) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// receiver stall pattern: phases of none, light and heavy stalling
	always @(negedge clk) begin
		int ph;
		ph = int'(($time / 64'd20000) % 64'd3);
		if (!arst_n)
			out_stall <= 1'b0;
		else if (ph == 0)
			out_stall <= 1'b0;
		else if (ph == 1)
			out_stall <= ($urandom_range(0, 3) == 0);
		else
			out_stall <= ($urandom_range(0, 3) != 0);
	end

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, val);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending_bytes.size() != 0)
			@(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	// one transaction on the input channel, with bursty gaps
	task automatic send_byte(input logic [7:0] b, input logic [23:0] len, input logic first,
			input logic [31:0] stamp);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		in_valid <= 1'b1;
		nal_byte <= b;
		nal_length <= len;
		first_of_nal <= first;
		stamp_ms <= stamp;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_input(b, len, first, stamp);
		@(negedge clk);
	endtask

	task automatic send_unit(input int len, input int cut, input logic [7:0] hdr);
		logic [31:0] st;
		st = $urandom;
		for (int i = 0; i < len && i < cut; i++)
			send_byte(i == 0 ? hdr : 8'($urandom), 24'(len), i == 0,
				i == 0 ? st : 32'($urandom));
	endtask

	function automatic logic [7:0] rand_hdr();
		logic [7:0] h;
		h = 8'($urandom);
		if ($urandom_range(0, 2) == 0)
			h[4:0] = IDR_TYPE;
		return h;
	endfunction

	initial begin
		int n;
		int mtu_now;
		sb = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		nal_byte = '0;
		nal_length = '0;
		first_of_nal = 1'b0;
		stamp_ms = '0;
		burst_left = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed part at reset settings, small and zero mtu, and the largest mtu
		send_unit(1, 1, 8'h65);
		send_unit(3, 3, 8'h41);
		drain();
		write_reg(REG_MTU, 32'd8);
		write_reg(REG_PT, 32'd127);
		write_reg(REG_CHAN, 32'd255);
		write_reg(REG_SSRC, 32'hffffffff);
		write_reg(REG_TICKS, 32'h7fffff);
		write_reg(REG_CYCLE, 32'hffffffff);
		send_unit(6, 6, 8'hff);
		send_unit(7, 7, 8'h65);
		send_unit(12, 12, 8'h00);
		send_byte(8'h11, 24'd0, 1'b1, 32'hffffffff);
		send_byte(8'h22, 24'd5, 1'b0, 32'd0);
		send_unit(9, 4, 8'h7c);
		send_unit(2, 2, 8'h05);
		drain();
		write_reg(REG_MTU, 32'd0);
		write_reg(REG_CYCLE, 32'd0);
		write_reg(REG_TICKS, 32'd0);
		send_unit(3, 3, 8'h65);
		drain();
		write_reg(REG_MTU, 32'hffff);
		write_reg(REG_PT, 32'd0);
		write_reg(REG_CHAN, 32'd0);
		write_reg(REG_SSRC, 32'd0);
		write_reg(REG_TICKS, 32'd1);
		write_reg(REG_CYCLE, 32'd1);
		send_unit(4, 4, 8'h25);
		drain();

		// random phases
		n = 0;
		while (n < 280) begin
			mtu_now = $urandom_range(3, 20);
			if ($urandom_range(0, 4) == 0)
				mtu_now = $urandom_range(0, 2);
			write_reg(REG_MTU, 32'(mtu_now));
			write_reg(REG_PT, 32'($urandom_range(0, 127)));
			write_reg(REG_CHAN, 32'($urandom_range(0, 255)));
			write_reg(REG_SSRC, $urandom);
			write_reg(REG_TICKS, 32'($urandom_range(0, 4194303) * 2 + $urandom_range(0, 1)));
			write_reg(REG_CYCLE, ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom);
			for (int u = 0; u < 6 && n < 280; u++) begin
				int len;
				int cut;
				int r;
				r = $urandom_range(0, 9);
				len = $urandom_range(1, 40);
				cut = len;
				if (r == 0)
					cut = $urandom_range(1, len);
				if (r == 1) begin
					send_byte(8'($urandom), 24'($urandom), 1'b0, $urandom);
					n++;
				end else if (r == 2) begin
					send_byte(8'($urandom), 24'd0, 1'b1, $urandom);
					n++;
				end else if (r == 3) begin
					send_unit(1, 1, rand_hdr());
					n++;
				end else begin
					send_unit(len, cut, rand_hdr());
					n += cut;
				end
			end
			drain();
		end
		// one long unit with wide length bits
		send_byte(8'h65, 24'hffffff, 1'b1, 32'hffffffff);
		send_byte(8'h00, 24'hffffff, 1'b0, 32'h0);
		send_byte(8'hff, 24'hffffff, 1'b0, 32'hffffffff);
		drain();
		if (sb.errors == 0 && sb.pending_bytes.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
